// File: hdl/rcdc_pkg.sv
// Shared types, constants and helpers for the Rabin content-defined chunker.
// No dependencies.
package rcdc_pkg;

  localparam int FP_W    = 64;
  localparam int COUNT_W = 21;
  localparam int BRK_W   = 32;
  localparam int A_W     = 5;
  localparam int IDX_W   = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_POLY   = 3'd0;
  localparam logic [IDX_W-1:0] REG_NORM   = 3'd1;
  localparam logic [IDX_W-1:0] REG_AVG    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MINLEN = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAXLEN = 3'd4;
  localparam logic [IDX_W-1:0] REG_BREAK  = 3'd5;

  localparam logic [FP_W-1:0]    POLY_RESET   = 64'd13827942727904890243;
  localparam logic [A_W-1:0]     AVG_RESET    = 5'd13;
  localparam logic [COUNT_W-1:0] MINLEN_RESET = 21'd2048;
  localparam logic [COUNT_W-1:0] MAXLEN_RESET = 21'd65536;
  localparam logic [BRK_W-1:0]   BREAK_RESET  = 32'd120;

  // Tables are linear in the index byte: one basis word per index bit.
  typedef logic [7:0][FP_W-1:0] basis_t;

  typedef struct packed {
    basis_t     append_basis;
    basis_t     remove_basis;
    logic [5:0] top_shift;
  } tables_t;

  typedef struct packed {
    logic               normalized;
    logic [A_W-1:0]     avg_log2;
    logic [COUNT_W-1:0] min_len;
    logic [COUNT_W-1:0] max_len;
    logic [BRK_W-1:0]   break_val;
  } cfg_t;

  function automatic logic [FP_W-1:0] basis_lookup(input basis_t b, input logic [7:0] j);
    logic [FP_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (j[i]) acc = acc ^ b[i];
    end
    return acc;
  endfunction

endpackage

// File: hdl/rcdc_tables.sv
// Table rebuild sequencer: derives append/remove basis words from the polynomial.
// Depends on rcdc_pkg.
module rcdc_tables import rcdc_pkg::*; #(
  parameter int WINDOW_BYTES = 48
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [FP_W-1:0] poly,
  output tables_t         tables,
  output logic            busy
);

  localparam int CNT_W = $clog2(WINDOW_BYTES);
  localparam logic [CNT_W-1:0] SP_LAST = CNT_W'(WINDOW_BYTES - 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEG  = 3'd1;
  localparam logic [2:0] S_AB   = 3'd2;
  localparam logic [2:0] S_SP   = 3'd3;
  localparam logic [2:0] S_RB   = 3'd4;

  logic [2:0]      st_r, st_nxt;
  logic [5:0]      k_r, k_nxt;
  logic [FP_W-1:0] v_r, v_nxt;
  logic [2:0]      b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  basis_t          ab_r, ab_nxt;
  basis_t          rb_r, rb_nxt;
  logic [5:0]      top_r, top_nxt;
  logic [FP_W-1:0] v_x;
  logic [FP_W-1:0] v_app;
  logic [FP_W-1:0] v_top;
  logic [5:0]      k_dec;

  assign k_dec = k_r - 6'd1;
  assign v_x   = (v_r << 1) ^ (v_r[k_dec] ? poly : '0);
  assign v_top = v_r >> top_r;
  assign v_app = (v_r << 8) ^ basis_lookup(ab_r, v_top[7:0]);

  always_comb begin
    st_nxt  = st_r;
    k_nxt   = k_r;
    v_nxt   = v_r;
    b_nxt   = b_r;
    cnt_nxt = cnt_r;
    ab_nxt  = ab_r;
    rb_nxt  = rb_r;
    top_nxt = top_r;
    unique case (st_r)
      S_IDLE: begin
      end
      S_DEG: begin
        if (!poly[k_r] && k_r != 6'd0) begin
          k_nxt = k_dec;
        end else if (poly[FP_W-1:8] == '0) begin
          ab_nxt  = '0;
          rb_nxt  = '0;
          top_nxt = '0;
          st_nxt  = S_IDLE;
        end else begin
          top_nxt = k_r - 6'd8;
          v_nxt   = poly ^ (64'd1 << k_r);
          b_nxt   = '0;
          st_nxt  = S_AB;
        end
      end
      S_AB: begin
        ab_nxt[b_r] = v_r ^ (64'd1 << ({1'b0, k_r} + {4'b0, b_r}));
        v_nxt = v_x;
        b_nxt = b_r + 3'd1;
        if (b_r == 3'd7) begin
          v_nxt   = 64'd1;
          cnt_nxt = '0;
          st_nxt  = S_SP;
        end
      end
      S_SP: begin
        v_nxt   = v_app;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == SP_LAST) begin
          b_nxt  = '0;
          st_nxt = S_RB;
        end
      end
      S_RB: begin
        rb_nxt[b_r] = v_r;
        v_nxt = v_x;
        b_nxt = b_r + 3'd1;
        if (b_r == 3'd7) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (start) begin
      st_nxt = S_DEG;
      k_nxt  = 6'd63;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_DEG;
      k_r  <= 6'd63;
    end else begin
      st_r <= st_nxt;
      k_r  <= k_nxt;
    end
    v_r   <= v_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
    ab_r  <= ab_nxt;
    rb_r  <= rb_nxt;
    top_r <= top_nxt;
  end

  assign busy                 = (st_r != S_IDLE);
  assign tables.append_basis  = ab_r;
  assign tables.remove_basis  = rb_r;
  assign tables.top_shift     = top_r;

endmodule

// File: hdl/rcdc_core.sv
// Per-byte chunking stage: window, rolling fingerprint, count and cut decision.
// Depends on rcdc_pkg.
module rcdc_core import rcdc_pkg::*; #(
  parameter int WINDOW_BYTES = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         data_byte,
  input  logic               end_of_data,
  input  cfg_t               cfg,
  input  tables_t            tables,
  output logic               cut,
  output logic [COUNT_W-1:0] chunk_length,
  output logic [FP_W-1:0]    rolling_value
);

  logic [FP_W-1:0]    fp_r, fp_nxt;
  logic [WINDOW_BYTES-1:0][7:0] win_r, win_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] count;
  logic               hashed;
  logic [FP_W-1:0]    f0, f0_top, h, mask;
  logic [6:0]         a7;
  logic               match;

  assign count  = (cnt_r != COUNT_MAX) ? cnt_r + COUNT_W'(1) : cnt_r;
  assign hashed = !(count < cfg.min_len || (count == cfg.min_len && end_of_data));
  assign f0     = fp_r ^ basis_lookup(tables.remove_basis, win_r[WINDOW_BYTES-1]);
  assign f0_top = f0 >> tables.top_shift;
  assign h      = {f0[FP_W-9:0], data_byte} ^ basis_lookup(tables.append_basis, f0_top[7:0]);
  assign a7     = {2'b0, cfg.avg_log2};

  always_comb begin
    if (!cfg.normalized) begin
      mask = (64'd1 << a7) - 64'd1;
    end else if ({43'b0, count} < (64'd1 << a7)) begin
      mask = (64'd1 << (a7 + 7'd1)) - 64'd1;
    end else if (a7 == 7'd0) begin
      mask = '0;
    end else begin
      mask = (64'd1 << (a7 - 7'd1)) - 64'd1;
    end
  end

  assign match         = ((h & mask) == {32'b0, cfg.break_val});
  assign cut           = hashed ? (match || count >= cfg.max_len || end_of_data) : end_of_data;
  assign chunk_length  = count;
  assign rolling_value = hashed ? h : '0;

  always_comb begin
    fp_nxt  = fp_r;
    win_nxt = win_r;
    cnt_nxt = cnt_r;
    if (fire) begin
      if (cut) begin
        fp_nxt  = '0;
        win_nxt = '0;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = count;
        if (hashed) begin
          fp_nxt  = h;
          win_nxt = {win_r[WINDOW_BYTES-2:0], data_byte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r  <= '0;
      win_r <= '0;
      cnt_r <= '0;
    end else begin
      fp_r  <= fp_nxt;
      win_r <= win_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fire && cut |=> cnt_r == '0 && fp_r == '0)
    else $error("chunk state not cleared after cut");
  assert property (@(posedge clk) disable iff (!rst_n) fire && !hashed && !cut |=> $stable(fp_r))
    else $error("fingerprint moved on unhashed byte");

endmodule

// File: hdl/rabin_content_defined_chunker.sv
// Top level of the Rabin content-defined chunker: config registers, handshakes.
// Depends on rcdc_pkg, rcdc_tables, rcdc_core.
//
// One byte is accepted per clock while no table rebuild runs and the output is not
// stalled. Each byte gives one result word via the input register, then the
// fingerprint/cut stage into the output register. After reset and after every
// polynomial write, a table rebuild sequencer derives the append and remove tables;
// in_ready stays low during the degree scan, two basis passes and the window power
// steps (a polynomial below 256 needs only the scan). Other register writes take
// effect at once. The user must write configuration only while the block is idle;
// the block itself does not enforce it.
module rabin_content_defined_chunker import rcdc_pkg::*; #(
  parameter int WINDOW_BYTES = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_cut,
  output logic [COUNT_W-1:0] out_chunk_length,
  output logic [FP_W-1:0]    out_rolling_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [FP_W-1:0]    cfg_data
);

  logic [FP_W-1:0] poly_r;
  cfg_t            cfg_r;
  logic            cfg_we, poly_we;
  tables_t         tables;
  logic            busy;

  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            s1_end_r;
  logic            advance, fire, in_fire;

  logic               c_cut;
  logic [COUNT_W-1:0] c_len;
  logic [FP_W-1:0]    c_rv;
  logic               out_valid_r;
  logic               out_cut_r;
  logic [COUNT_W-1:0] out_len_r;
  logic [FP_W-1:0]    out_rv_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign poly_we   = cfg_we && cfg_index == REG_POLY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r          <= POLY_RESET;
      cfg_r.normalized <= 1'b0;
      cfg_r.avg_log2  <= AVG_RESET;
      cfg_r.min_len   <= MINLEN_RESET;
      cfg_r.max_len   <= MAXLEN_RESET;
      cfg_r.break_val <= BREAK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLY:   poly_r          <= cfg_data;
        REG_NORM:   cfg_r.normalized <= cfg_data[0];
        REG_AVG:    cfg_r.avg_log2  <= cfg_data[A_W-1:0];
        REG_MINLEN: cfg_r.min_len   <= cfg_data[COUNT_W-1:0];
        REG_MAXLEN: cfg_r.max_len   <= cfg_data[COUNT_W-1:0];
        REG_BREAK:  cfg_r.break_val <= cfg_data[BRK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rcdc_tables #(.WINDOW_BYTES(WINDOW_BYTES)) u_tables (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (poly_we),
    .poly   (poly_we ? cfg_data : poly_r),
    .tables (tables),
    .busy   (busy)
  );

  assign advance  = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && advance;
  assign in_ready = !busy && (!s1_valid_r || advance);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
    if (in_fire) begin
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_end_of_data;
    end
  end

  rcdc_core #(.WINDOW_BYTES(WINDOW_BYTES)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (s1_byte_r),
    .end_of_data   (s1_end_r),
    .cfg           (cfg_r),
    .tables        (tables),
    .cut           (c_cut),
    .chunk_length  (c_len),
    .rolling_value (c_rv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
    if (fire) begin
      out_cut_r <= c_cut;
      out_len_r <= c_len;
      out_rv_r  <= c_rv;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cut           = out_cut_r;
  assign out_chunk_length  = out_len_r;
  assign out_rolling_value = out_rv_r;

  assert property (@(posedge clk) disable iff (!rst_n) !(busy && in_ready))
    else $error("input accepted during table rebuild");
  assert property (@(posedge clk) disable iff (!rst_n) poly_we |=> busy && !in_ready)
    else $error("polynomial write did not start rebuild");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |-> out_len_r != '0)
    else $error("result with zero chunk length");

endmodule

// File: verif/rabin_content_defined_chunker_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for rabin_content_defined_chunker: drives bytes with random gaps,
// predicts cut/length/fingerprint per byte and compares every output word.
// Depends on rcdc_pkg and the chunker RTL.
module rabin_content_defined_chunker_tb;
  import rcdc_pkg::*;

  localparam int WIN = 48;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic               cut;
    logic [COUNT_W-1:0] len;
    logic [FP_W-1:0]    fp;
  } chunk_word_t;

  class chunk_board;
    chunk_word_t pending[$];
    int errors;
    int cuts;
    int words;

    function void note_byte(chunk_word_t w);
      pending.push_back(w);
    endfunction

    task report(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_word(logic c, logic [COUNT_W-1:0] l, logic [FP_W-1:0] f);
      chunk_word_t w;
      if (pending.size() == 0) begin
        report("output word with nothing pending");
        return;
      end
      w = pending.pop_front();
      words++;
      if (c) cuts++;
      if (c !== w.cut) report($sformatf("cut %0b, want %0b", c, w.cut));
      if (l !== w.len) report($sformatf("chunk_length %0d, want %0d", l, w.len));
      if (f !== w.fp) report($sformatf("rolling_value %h, want %h", f, w.fp));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_data_byte;
  logic               in_end_of_data;
  logic               out_valid;
  logic               out_ready;
  logic               out_cut;
  logic [COUNT_W-1:0] out_chunk_length;
  logic [FP_W-1:0]    out_rolling_value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [FP_W-1:0]    cfg_data;

  rabin_content_defined_chunker #(.WINDOW_BYTES(WIN)) i_dut (.*);

  chunk_board board;

  // predictor copy of configuration and chunk state
  logic [FP_W-1:0]    m_poly;
  logic               m_norm;
  logic [A_W-1:0]     m_avg;
  logic [COUNT_W-1:0] m_min;
  logic [COUNT_W-1:0] m_max;
  logic [BRK_W-1:0]   m_brk;
  logic [FP_W-1:0]    fp_acc;
  logic [7:0]         win_mem [WIN];
  int                 win_pos;
  logic [COUNT_W-1:0] run_len;
  logic [FP_W-1:0]    push_tab [256];
  logic [FP_W-1:0]    drop_tab [256];
  int                 msb_shift;

  int in_idle_mode, out_idle_mode;
  int out_hold;
  int bytes_sent, cfg_writes;
  int cycles;

  function automatic logic [FP_W-1:0] gf_reduce(logic [127:0] v, logic [FP_W-1:0] d, int k);
    for (int i = 127; i >= k; i--)
      if (v[i]) v = v ^ ({64'd0, d} << (i - k));
    return v[63:0];
  endfunction

  function automatic logic [FP_W-1:0] gf_mul(logic [FP_W-1:0] x, logic [FP_W-1:0] y,
                                              logic [FP_W-1:0] d, int k);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < 64; i++)
      if (x[i]) v = v ^ ({64'd0, y} << i);
    return gf_reduce(v, d, k);
  endfunction

  function automatic logic [FP_W-1:0] slide_in(logic [FP_W-1:0] f, logic [7:0] b);
    logic [7:0] idx;
    idx = 8'((f >> msb_shift) & 64'hFF);
    return ((f << 8) | {56'd0, b}) ^ push_tab[idx];
  endfunction

  function automatic void rebuild_tables();
    int k;
    logic [FP_W-1:0] t1, pw;
    if (m_poly < 64'h100) begin
      for (int j = 0; j < 256; j++) begin
        push_tab[j] = '0;
        drop_tab[j] = '0;
      end
      msb_shift = 0;
      return;
    end
    k = 63;
    while (!m_poly[k]) k--;
    msb_shift = k - 8;
    t1 = gf_reduce(128'd1 << k, m_poly, k);
    for (int j = 0; j < 256; j++)
      push_tab[j] = gf_mul(64'(j), t1, m_poly, k) | (64'(j) << k);
    pw = 64'd1;
    for (int i = 1; i < WIN; i++) pw = slide_in(pw, 8'd0);
    for (int j = 0; j < 256; j++)
      drop_tab[j] = gf_mul(64'(j), pw, m_poly, k);
  endfunction

  function automatic void clear_chunk();
    fp_acc = '0;
    for (int i = 0; i < WIN; i++) win_mem[i] = '0;
    win_pos = WIN - 1;
    run_len = '0;
  endfunction

  function automatic chunk_word_t chunk_step(logic [7:0] b, logic eod);
    chunk_word_t w;
    logic [COUNT_W-1:0] cnt;
    logic [7:0] old;
    logic [FP_W-1:0] mask;
    int a;
    cnt = (run_len < COUNT_MAX) ? run_len + COUNT_W'(1) : COUNT_MAX;
    w.len = cnt;
    w.fp = '0;
    a = m_avg;
    if (cnt < m_min || (cnt == m_min && eod)) begin
      w.cut = eod;
    end else begin
      win_pos = (win_pos + 1 >= WIN) ? 0 : win_pos + 1;
      old = win_mem[win_pos];
      win_mem[win_pos] = b;
      fp_acc = slide_in(fp_acc ^ drop_tab[old], b);
      w.fp = fp_acc;
      if (!m_norm) mask = (64'd1 << a) - 1;
      else if (64'(cnt) < (64'd1 << a)) mask = (64'd1 << (a + 1)) - 1;
      else mask = (a == 0) ? 64'd0 : (64'd1 << (a - 1)) - 1;
      w.cut = ((w.fp & mask) == {32'd0, m_brk}) || cnt >= m_max || eod;
    end
    if (w.cut) clear_chunk();
    else run_len = cnt;
    return w;
  endfunction

  function automatic int pick_gap(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check, then choose the next ready level
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        board.check_word(out_cut, out_chunk_length, out_rolling_value);
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else if (out_idle_mode == 0) out_ready <= 1'b1;
      else if (out_idle_mode == 2 && $urandom_range(0, 99) < 3) begin
        out_hold = $urandom_range(10, 40);
        out_ready <= 1'b0;
      end
      else out_ready <= ($urandom_range(0, 99) < 70);
    end
  end

  task send_byte(logic [7:0] b, logic eod);
    int gap;
    gap = pick_gap(in_idle_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_data <= eod;
    do @(posedge clk); while (!in_ready);
    board.note_byte(chunk_step(b, eod));
    bytes_sent++;
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [IDX_W-1:0] idx, logic [FP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_POLY: begin
        m_poly = v;
        rebuild_tables();
      end
      REG_NORM:   m_norm = v[0];
      REG_AVG:    m_avg = v[A_W-1:0];
      REG_MINLEN: m_min = v[COUNT_W-1:0];
      REG_MAXLEN: m_max = v[COUNT_W-1:0];
      REG_BREAK:  m_brk = v[BRK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task set_all(logic [63:0] p, logic n, int a, int mn, int mx, logic [31:0] bv);
    wait_idle();
    write_reg(REG_POLY, p);
    write_reg(REG_NORM, {63'd0, n});
    write_reg(REG_AVG, 64'(a));
    write_reg(REG_MINLEN, 64'(mn));
    write_reg(REG_MAXLEN, 64'(mx));
    write_reg(REG_BREAK, {32'd0, bv});
  endtask

  function automatic logic [63:0] rand_poly();
    logic [63:0] p;
    int k;
    p = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return POLY_RESET;
      1: return 64'($urandom_range(0, 255));
      default: begin
        k = $urandom_range(8, 63);
        p = p & ((64'd1 << k) - 1);
        return p | (64'd1 << k);
      end
    endcase
  endfunction

  initial begin
    logic [7:0] b;
    int a, mn, mx, r, run;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_end_of_data = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_mode = 0;
    out_idle_mode = 0;
    out_hold = 0;
    m_poly = POLY_RESET;
    m_norm = 1'b0;
    m_avg = AVG_RESET;
    m_min = MINLEN_RESET;
    m_max = MAXLEN_RESET;
    m_brk = BREAK_RESET;
    clear_chunk();
    rebuild_tables();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: degree-8 poly, end at minimum, forced max cuts
    for (int i = 0; i < 4; i++) send_byte(8'hA5, 1'b0);
    send_byte(8'hFF, 1'b1);
    set_all(64'h11B, 1'b0, 2, 3, 6, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    for (int i = 0; i < 7; i++) send_byte(8'(i * 37), 1'b0);
    // low-degree poly, zero max, halved mask at A zero
    set_all(64'h7, 1'b1, 0, 1, 0, 32'd0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b1);
    // maximum below minimum
    set_all(POLY_RESET, 1'b1, 31, 5, 2, 32'd0);
    for (int i = 0; i < 6; i++) send_byte(8'h55, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 7);
      mn = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      r = $urandom_range(0, 9);
      mx = (r == 0) ? 0 : (r == 1) ? $urandom_range(1, mn) :
           (r == 2) ? 1048576 : mn + $urandom_range(0, 200);
      set_all(rand_poly(), 1'($urandom), a, mn, mx,
              ($urandom_range(0, 3) == 0) ? $urandom : (32'($urandom) & ((32'd1 << (a % 32)) - 1)));
      in_idle_mode = ph % 3;
      out_idle_mode = (ph + 1) % 3;
      run = 0;
      for (int i = 0; i < 250; i++) begin
        if (run == 0 && $urandom_range(0, 19) == 0) begin
          run = $urandom_range(5, 60);
          b = 8'($urandom);
        end
        if (run > 0) run--;
        else b = 8'($urandom);
        send_byte(b, $urandom_range(0, 99) < 2);
      end
    end

    // back to the reset values, a poly write landing mid-chunk
    set_all(POLY_RESET, 1'b0, 13, 2048, 65536, 32'd120);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), 1'b0);
    wait_idle();
    write_reg(REG_POLY, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 39);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("sent %0d bytes over %0d register writes; checked %0d words, %0d cuts",
             bytes_sent, cfg_writes, board.words, board.cuts);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
